// ===== rtl/rgb_command_packet_to_pwm_levels_top_defines.svh =====
// Assertion helpers used by the RTL top.
`ifndef RGB_COMMAND_PACKET_TO_PWM_LEVELS_TOP_DEFINES_SVH
`define RGB_COMMAND_PACKET_TO_PWM_LEVELS_TOP_DEFINES_SVH

// Same-cycle implication check.
`define RGBPWM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgbpwm check failed");

// Next-cycle implication check.
`define RGBPWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgbpwm check failed");

`endif

// ===== rtl/rgbpwm_pkg.sv =====
package rgbpwm_pkg;

   // Packet framing codes
   localparam logic [7:0] START_BYTE = 8'd254;
   localparam logic [7:0] TYPE_SET   = 8'd0;
   localparam logic [7:0] TYPE_RESET = 8'd1;
   localparam logic       KIND_SET   = 1'b0;

   // PWM top after reset
   localparam logic [15:0] WRAP_RESET = 16'd780;

   localparam int unsigned HEAD_SLOTS = 3;

   // Completed set packet handed from the framer to the scaler
   typedef struct packed {
      logic                        valid;
      logic [HEAD_SLOTS-1:0][7:0]  color;
   } frame_result_type;

   // Scaler pipeline status
   typedef struct packed {
      logic prod_valid;
      logic prod_ready;
   } scaler_status_type;

endpackage

// ===== rtl/rgbpwm_framer.sv =====
module rgbpwm_framer #(
   parameter int MAX_PAYLOAD = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [7:0]                   rx_byte,
   output rgbpwm_pkg::frame_result_type frame
);

   localparam int POS_W = $clog2(MAX_PAYLOAD + 3);
   localparam int CMP_W = (POS_W > 9) ? POS_W : 9;

   localparam logic [POS_W-1:0] POS_IDLE    = POS_W'(0);
   localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LENGTH  = POS_W'(2);
   localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(3);
   localparam logic [POS_W-1:0] POS_LAST    = POS_W'(MAX_PAYLOAD + 2);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             kind_ff, kind_in;
   logic [8:0]       end_ff, end_in;
   logic [rgbpwm_pkg::HEAD_SLOTS-1:0][7:0] head_ff, head_in;
   logic             last;
   logic             fire;

   // Last payload byte: declared length reached or payload cap hit
   assign last = (CMP_W'(pos_ff) >= CMP_W'(end_ff)) || (pos_ff >= POS_LAST);

   // Framing next state
   always_comb begin
      pos_in  = pos_ff;
      kind_in = kind_ff;
      end_in  = end_ff;
      head_in = head_ff;
      fire    = 1'b0;
      if (accept) begin
         if (pos_ff == POS_IDLE) begin
            if (rx_byte == rgbpwm_pkg::START_BYTE) begin
               pos_in = POS_TYPE;
            end
         end else if (pos_ff == POS_TYPE) begin
            if (rx_byte == rgbpwm_pkg::TYPE_SET || rx_byte == rgbpwm_pkg::TYPE_RESET) begin
               kind_in = rx_byte[0];
               pos_in  = POS_LENGTH;
            end else begin
               pos_in = POS_IDLE;
            end
         end else if (pos_ff == POS_LENGTH) begin
            end_in = 9'(rx_byte) + 9'd2;
            pos_in = POS_PAYLOAD;
         end else begin
            for (int i = 0; i < rgbpwm_pkg::HEAD_SLOTS; i++) begin
               if (pos_ff == POS_W'(3 + i)) begin
                  head_in[i] = rx_byte;
               end
               // slot after the final byte is cleared
               if (last && i >= 1 && pos_ff == POS_W'(2 + i)) begin
                  head_in[i] = 8'h00;
               end
            end
            if (last) begin
               pos_in = POS_IDLE;
               fire   = (kind_ff == rgbpwm_pkg::KIND_SET);
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   // Framing state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_IDLE;
         kind_ff <= 1'b0;
         end_ff  <= 9'd0;
         head_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         kind_ff <= kind_in;
         end_ff  <= end_in;
         head_ff <= head_in;
      end
   end

   // Colors go out with the byte that completes the packet
   assign frame.valid = fire;
   assign frame.color = head_in;

endmodule

// ===== rtl/rgbpwm_scaler.sv =====
module rgbpwm_scaler (
   input  logic                          clock,
   input  logic                          reset,
   input  rgbpwm_pkg::frame_result_type  frame,
   input  logic [15:0]                   wrap,
   input  logic                          rsp_tready,
   output rgbpwm_pkg::scaler_status_type status,
   output logic                          rsp_tvalid,
   output logic [47:0]                   rsp_tdata
);

   // floor(x / 255): estimate from x/256 + x/2^16 + x/2^24, low by at most one
   function automatic logic [15:0] div_by_255(input logic [23:0] x);
      logic [24:0] t;
      logic [16:0] q0;
      logic [24:0] r0;
      t  = 25'(x) + 25'(x >> 8) + 25'(x >> 16);
      q0 = t[24:8];
      r0 = 25'(x) - (25'({q0, 8'h00}) - 25'(q0));
      return (r0 >= 25'd255) ? 16'(q0 + 17'd1) : q0[15:0];
   endfunction

   logic                                     prod_valid_ff, prod_valid_in;
   logic [rgbpwm_pkg::HEAD_SLOTS-1:0][23:0]  prod_ff, prod_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [rgbpwm_pkg::HEAD_SLOTS-1:0][15:0]  level_ff, level_in;
   logic                                     out_load;
   logic                                     prod_free;

   // Pipeline flow
   assign out_load  = prod_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign prod_free = !prod_valid_ff || out_load;

   always_comb begin
      prod_valid_in = frame.valid ? 1'b1 : (out_load ? 1'b0 : prod_valid_ff);
      rsp_valid_in  = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // Products and scaled levels
   always_comb begin
      for (int i = 0; i < rgbpwm_pkg::HEAD_SLOTS; i++) begin
         prod_in[i]  = {8'h00, wrap} * {16'h0000, frame.color[i]};
         level_in[i] = div_by_255(prod_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (frame.valid) begin
         prod_ff <= prod_in;
      end
      if (out_load) begin
         level_ff <= level_in;
      end
   end

   assign status.prod_valid = prod_valid_ff;
   assign status.prod_ready = prod_free;
   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_tdata         = {level_ff[2], level_ff[1], level_ff[0]};

endmodule

// ===== rtl/rgb_command_packet_to_pwm_levels_top.sv =====
// Throughput: one received byte per cycle while the output is not stalled.
// Result: a set packet's levels reach rsp_tvalid through the multiply stage, then the
//   divide-by-255 stage, which waits while the output is stalled.
// Reset (synchronous): framer back to idle, kept colors cleared, PWM top set to 780,
//   pipeline emptied.
`include "rgb_command_packet_to_pwm_levels_top_defines.svh"

module rgb_command_packet_to_pwm_levels_top #(
   parameter int MAX_PAYLOAD = 128
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [7:0] rx_byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // rsp_tdata: [15:0] level_red, [31:16] level_green, [47:32] level_blue
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   // csr_data: [15:0] pwm_wrap_value
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   rgbpwm_pkg::frame_result_type  frame;
   rgbpwm_pkg::scaler_status_type status;
   logic [15:0] wrap_ff, wrap_in;
   logic        req_accept;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = status.prod_ready;
   assign csr_ready  = 1'b1;

   // PWM top register
   assign wrap_in = (csr_valid && csr_ready) ? csr_data : wrap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff <= rgbpwm_pkg::WRAP_RESET;
      end else begin
         wrap_ff <= wrap_in;
      end
   end

   rgbpwm_framer #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_framer (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_tdata),
      .frame   (frame)
   );

   rgbpwm_scaler u_scaler (
      .clock      (clock),
      .reset      (reset),
      .frame      (frame),
      .wrap       (wrap_ff),
      .rsp_tready (rsp_tready),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   // A packet completes only on an accepted transaction
   `RGBPWM_ASSERT_NOW(a_fire_on_accept, clock, reset, frame.valid, req_accept)
   // Full pipeline with a stalled output stops intake
   `RGBPWM_ASSERT_NOW(a_stall_blocks, clock, reset,
      status.prod_valid && rsp_tvalid && !rsp_tready, !req_tready)
   // A stalled product is not dropped
   `RGBPWM_ASSERT_NEXT(a_prod_kept, clock, reset,
      status.prod_valid && rsp_tvalid && !rsp_tready, status.prod_valid)

endmodule

// ===== tb/rgb_command_packet_to_pwm_levels_top_test.sv =====
`timescale 1ns / 100ps

module rgb_command_packet_to_pwm_levels_top_test;

   localparam int          FRAME_PAYLOAD_MAX = 128;
   localparam int unsigned FULL_SCALE        = 255;
   localparam int          PIPE_SETTLE       = 6;
   localparam logic [7:0]  TYPE_BAD          = 8'd2;
   localparam int          WRAP_PHASES       = 6;
   localparam int          PHASE_ITEMS       = 50;

   // Three compare levels, red in the low bits as on rsp_tdata
   typedef struct packed {
      logic [15:0] blue;
      logic [15:0] green;
      logic [15:0] red;
   } pwm_levels_type;

   typedef struct {
      logic [7:0]     rx;
      bit             fixed;
      pwm_levels_type levels;
   } directed_row_type;

   localparam pwm_levels_type NO_LEVELS = '0;
   // 780 * 255 / 255 and 780 * 128 / 255 at the reset PWM top
   localparam pwm_levels_type FIRST_SET_LEVELS =
      '{blue: 16'd391, green: 16'd0, red: 16'd780};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [47:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   // Framer and scaler state as the block should hold it
   int unsigned frame_pos;
   int unsigned frame_end;
   logic        frame_kind;
   logic [7:0]  color_slots [rgbpwm_pkg::HEAD_SLOTS];
   logic [15:0] wrap_level;

   pwm_levels_type   expected_levels_q [$];
   pwm_levels_type   got_levels;
   pwm_levels_type   want_levels;
   directed_row_type directed_rows [21];
   logic [15:0]      wrap_plan [WRAP_PHASES];

   int  error_count    = 0;
   int  results_seen   = 0;
   int  framed_items   = 0;
   int  burst_left     = 0;
   int  stall_cycle    = 0;
   bit  sender_gaps    = 1'b1;

   rgb_command_packet_to_pwm_levels_top #(
      .MAX_PAYLOAD (FRAME_PAYLOAD_MAX)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // Colour byte to compare level at the current PWM top
   function automatic logic [15:0] scale_level(input logic [7:0] color);
      logic [31:0] product;
      product = {16'd0, wrap_level} * {24'd0, color};
      return 16'(product / FULL_SCALE);
   endfunction

   // Advance the framer by one received byte; emit is set when a set packet completes
   task automatic frame_byte(input logic [7:0] rx, output bit emit,
                             output pwm_levels_type lv);
      int unsigned slot;
      bit          last;
      emit = 1'b0;
      lv   = NO_LEVELS;
      if (frame_pos == 0) begin
         if (rx == rgbpwm_pkg::START_BYTE) frame_pos = 1;
      end else if (frame_pos == 1) begin
         if (rx == rgbpwm_pkg::TYPE_SET || rx == rgbpwm_pkg::TYPE_RESET) begin
            frame_kind = rx[0];
            frame_pos  = 2;
         end else begin
            frame_pos = 0;
         end
      end else if (frame_pos == 2) begin
         frame_end = int'(rx) + 2;
         frame_pos = 3;
      end else begin
         slot = frame_pos - 3;
         last = (frame_pos >= frame_end) || (slot + 1 >= FRAME_PAYLOAD_MAX);
         if (slot < rgbpwm_pkg::HEAD_SLOTS) color_slots[slot] = rx;
         if (!last) begin
            frame_pos++;
         end else begin
            // slot after the final byte is cleared
            if (slot + 1 < rgbpwm_pkg::HEAD_SLOTS) color_slots[slot + 1] = 8'd0;
            frame_pos = 0;
            if (frame_kind == rgbpwm_pkg::KIND_SET) begin
               emit     = 1'b1;
               lv.red   = scale_level(color_slots[0]);
               lv.green = scale_level(color_slots[1]);
               lv.blue  = scale_level(color_slots[2]);
            end
         end
      end
   endtask

   // One byte transaction on the request side, with bursts and gaps
   task automatic send_byte(input logic [7:0] rx, input bit fixed,
                            input pwm_levels_type fixed_lv);
      bit             emit;
      pwm_levels_type lv;
      if (sender_gaps && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      do @(posedge clock); while (!req_tready);
      frame_byte(rx, emit, lv);
      if (emit) expected_levels_q.push_back(fixed ? fixed_lv : lv);
   endtask

   // Pause until every result is out, then let the pipeline settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_levels_q.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   // Close any open packet so the framer is idle before a register write
   task automatic flush_frame();
      while (frame_pos != 0) send_byte((frame_pos == 1) ? TYPE_BAD : 8'd0, 1'b0, NO_LEVELS);
   endtask

   task automatic write_wrap(input logic [15:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      wrap_level = value;
   endtask

   // Well-formed packet with random colours
   task automatic send_frame(input logic [7:0] kind_byte, input int len);
      int         count;
      logic [7:0] color;
      send_byte(rgbpwm_pkg::START_BYTE, 1'b0, NO_LEVELS);
      send_byte(kind_byte, 1'b0, NO_LEVELS);
      send_byte(8'(len), 1'b0, NO_LEVELS);
      count = (len == 0) ? 1 : len;
      if (count > FRAME_PAYLOAD_MAX) count = FRAME_PAYLOAD_MAX;
      repeat (count) begin
         if ($urandom_range(0, 6) == 0) color = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         else color = 8'($urandom_range(0, 255));
         send_byte(color, 1'b0, NO_LEVELS);
      end
      framed_items += count + 3;
   endtask

   task automatic send_random_packet();
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         len = $urandom_range(0, 99);
         if (len < 60) len = $urandom_range(0, 4);
         else if (len < 90) len = $urandom_range(5, 12);
         else if (len < 98) len = $urandom_range(13, 60);
         else len = $urandom_range(120, 255);
         send_frame(($urandom_range(0, 99) < 85) ? rgbpwm_pkg::TYPE_SET
                                                 : rgbpwm_pkg::TYPE_RESET, len);
      end else if (pick < 90) begin
         // line noise between packets
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_LEVELS);
      end else if (pick < 95) begin
         send_byte(rgbpwm_pkg::START_BYTE, 1'b0, NO_LEVELS);
         send_byte(8'($urandom_range(2, 255)), 1'b0, NO_LEVELS);
      end else begin
         // truncated packet; the next bytes get swallowed as payload
         len = $urandom_range(4, 12);
         send_byte(rgbpwm_pkg::START_BYTE, 1'b0, NO_LEVELS);
         send_byte(rgbpwm_pkg::TYPE_SET, 1'b0, NO_LEVELS);
         send_byte(8'(len), 1'b0, NO_LEVELS);
         repeat ($urandom_range(1, len - 1))
            send_byte(8'($urandom_range(0, 255)), 1'b0, NO_LEVELS);
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
         error_count++;
      end
   endtask

   // Result side: check each transaction, then stall on a rotating pattern
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_levels = pwm_levels_type'(rsp_tdata);
            if (expected_levels_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $realtime, rsp_tdata);
               error_count++;
            end else begin
               want_levels = expected_levels_q.pop_front();
               check_field("level_red", want_levels.red, got_levels.red);
               check_field("level_green", want_levels.green, got_levels.green);
               check_field("level_blue", want_levels.blue, got_levels.blue);
               results_seen++;
            end
         end
         stall_cycle++;
         case ((stall_cycle >> 7) & 3)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ((stall_cycle & 7) != 0);
            default: rsp_tready <= ($urandom_range(0, 2) == 0);
         endcase
      end
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("rgb_command_packet_to_pwm_levels_top_test failed");
      $finish;
   end

   initial begin
      frame_pos   = 0;
      frame_end   = 0;
      frame_kind  = rgbpwm_pkg::KIND_SET;
      color_slots = '{8'd0, 8'd0, 8'd0};
      wrap_level  = rgbpwm_pkg::WRAP_RESET;

      // Directed bytes at the reset PWM top
      directed_rows = '{
         '{8'h00,                  1'b0, NO_LEVELS},         // noise while idle
         '{8'hFF,                  1'b0, NO_LEVELS},
         '{rgbpwm_pkg::TYPE_RESET, 1'b0, NO_LEVELS},
         '{rgbpwm_pkg::START_BYTE, 1'b0, NO_LEVELS},         // set, three colours
         '{rgbpwm_pkg::TYPE_SET,   1'b0, NO_LEVELS},
         '{8'd3,                   1'b0, NO_LEVELS},
         '{8'd255,                 1'b0, NO_LEVELS},
         '{8'd0,                   1'b0, NO_LEVELS},
         '{8'd128,                 1'b1, FIRST_SET_LEVELS},
         '{rgbpwm_pkg::START_BYTE, 1'b0, NO_LEVELS},         // bad type aborts
         '{TYPE_BAD,               1'b0, NO_LEVELS},
         '{rgbpwm_pkg::START_BYTE, 1'b0, NO_LEVELS},         // reset packet, length zero
         '{rgbpwm_pkg::TYPE_RESET, 1'b0, NO_LEVELS},
         '{8'd0,                   1'b0, NO_LEVELS},
         '{8'd7,                   1'b0, NO_LEVELS},
         '{rgbpwm_pkg::START_BYTE, 1'b0, NO_LEVELS},         // short set: one byte
         '{rgbpwm_pkg::TYPE_SET,   1'b0, NO_LEVELS},
         '{8'd1,                   1'b0, NO_LEVELS},
         '{8'd255,                 1'b0, NO_LEVELS},
         '{rgbpwm_pkg::START_BYTE, 1'b0, NO_LEVELS},         // start byte as type aborts
         '{rgbpwm_pkg::START_BYTE, 1'b0, NO_LEVELS}
      };

      wrap_plan = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 65534)), 16'd255,
                    rgbpwm_pkg::WRAP_RESET};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx, directed_rows[i].fixed, directed_rows[i].levels);

      // Random packets over several PWM top settings
      for (int p = 0; p < WRAP_PHASES; p++) begin
         flush_frame();
         write_wrap(wrap_plan[p]);
         sender_gaps = (p % 3 != 1);
         if (p == 1) send_frame(rgbpwm_pkg::TYPE_SET, 255);
         begin
            int target;
            target = framed_items + PHASE_ITEMS;
            while (framed_items < target) send_random_packet();
         end
      end

      wait_drained();

      $display("Sent %0d bytes in framed packets plus noise over %0d PWM top settings,",
               framed_items, WRAP_PHASES);
      $display("checked %0d level results.", results_seen);
      if (error_count == 0 && expected_levels_q.size() == 0) begin
         $display("rgb_command_packet_to_pwm_levels_top_test passed");
      end else begin
         $display("rgb_command_packet_to_pwm_levels_top_test failed");
      end
      $finish;
   end

endmodule
